// File: src/sau_pkg.sv
// Shared types and constants of the stack arithmetic unit.
package sau_pkg;

  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned DEPTH_W     = 9;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned BIT_W       = $clog2(WORD_W);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_MOD  = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_WB,
    S_DONE
  } state_e;

endpackage

// File: src/sau_if.sv
// Valid/ready channel interfaces of the stack arithmetic unit.
interface sau_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [sau_pkg::OP_W-1:0]      opcode;
  logic signed [sau_pkg::WORD_W-1:0]    push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface sau_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sau_pkg::WORD_W-1:0]    top_value;
  logic        [sau_pkg::DEPTH_W-1:0]   depth;
  logic        [sau_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output top_value, output depth, output status, input ready);
  modport sink   (input valid, input top_value, input depth, input status, output ready);
endinterface

// File: src/sau_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sau_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: src/stack_arithmetic_unit.sv
// Stack arithmetic unit: stack in RAM, top word cached, iterative divider.
//
//   channel | dir | fields                       | word accepted when
//   in_i    | in  | opcode, push_value           | valid && ready
//   out_o   | out | top_value, depth, status     | valid && ready
//
// Push, unused opcodes and a too-short stack go straight to the result; a
// zero divisor reads, then posts; add/sub/mul read, compute, write back, post;
// div/mod add the radix-2 divider that retires one quotient bit per cycle.
// Reset empties the stack; RAM contents are never cleared.
// The next word is accepted while a result still waits in the output
// register; a result stalls in the final state until that register frees.
module stack_arithmetic_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  sau_in_if.sink     in_i,
  sau_out_if.source  out_o
);

  localparam int unsigned W = sau_pkg::WORD_W;

  // Control state
  sau_pkg::state_e               state_q, state_d;
  logic [sau_pkg::CNT_W-1:0]     count_q, count_d;
  logic                          out_valid_q, out_valid_d;
  logic [sau_pkg::BIT_W-1:0]     bit_q, bit_d;

  // Payload state
  logic [sau_pkg::OP_W-1:0]      op_q, op_d;
  sau_pkg::status_e              status_q, status_d;
  logic [W-1:0]                  top_q, top_d;
  logic [W-1:0]                  res_q, res_d;
  logic [W-1:0]                  dvd_q, dvd_d;
  logic [W-1:0]                  rem_q, rem_d;
  logic [W-1:0]                  dsr_q, dsr_d;
  logic                          qneg_q, qneg_d;
  logic                          rneg_q, rneg_d;
  logic [W-1:0]                  out_top_q, out_top_d;
  logic [sau_pkg::DEPTH_W-1:0]   out_depth_q, out_depth_d;
  logic [sau_pkg::STATUS_W-1:0]  out_status_q, out_status_d;

  // RAM port
  logic                          ram_we;
  logic [sau_pkg::ADDR_W-1:0]    ram_waddr;
  logic [W-1:0]                  ram_wdata;
  logic [sau_pkg::ADDR_W-1:0]    ram_raddr;
  logic [W-1:0]                  ram_rdata;

  // Divider datapath
  logic [W:0]                    div_trial;
  logic [W:0]                    div_diff;
  logic                          div_ge;
  logic [W-1:0]                  div_rem_nx;
  logic [W-1:0]                  div_quo_nx;
  logic [W-1:0]                  cnt_minus2;

  logic                          in_fire;
  logic                          out_free;

  // Input is taken only in the idle state
  assign in_i.ready = (state_q == sau_pkg::S_IDLE);

  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign cnt_minus2 = W'(count_q) - W'(2);

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign div_trial  = {rem_q, dvd_q[W-1]};
  assign div_diff   = div_trial - {1'b0, dsr_q};
  assign div_ge     = !div_diff[W];
  assign div_rem_nx = div_ge ? div_diff[W-1:0] : div_trial[W-1:0];
  assign div_quo_nx = {dvd_q[W-2:0], div_ge};

  sau_ram #(
    .WIDTH (W),
    .DEPTH (sau_pkg::STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state, datapath and RAM control
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q;
    bit_d        = bit_q;
    op_d         = op_q;
    status_d     = status_q;
    top_d        = top_q;
    res_d        = res_q;
    dvd_d        = dvd_q;
    rem_d        = rem_q;
    dsr_d        = dsr_q;
    qneg_d       = qneg_q;
    rneg_d       = rneg_q;
    out_top_d    = out_top_q;
    out_depth_d  = out_depth_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_waddr    = count_q[sau_pkg::ADDR_W-1:0];
    ram_wdata    = in_i.push_value;
    ram_raddr    = cnt_minus2[sau_pkg::ADDR_W-1:0];

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      sau_pkg::S_IDLE: begin
        if (in_fire) begin
          op_d     = in_i.opcode;
          status_d = sau_pkg::ST_OK;
          state_d  = sau_pkg::S_DONE;
          case (in_i.opcode)
            sau_pkg::OP_PUSH: begin
              if (count_q >= sau_pkg::CNT_W'(sau_pkg::STACK_DEPTH)) begin
                status_d = sau_pkg::ST_FULL;
              end else begin
                ram_we  = 1'b1;
                top_d   = in_i.push_value;
                count_d = count_q + sau_pkg::CNT_W'(1);
              end
            end
            sau_pkg::OP_ADD, sau_pkg::OP_SUB, sau_pkg::OP_MUL,
            sau_pkg::OP_DIV, sau_pkg::OP_MOD: begin
              if (count_q < sau_pkg::CNT_W'(2)) begin
                status_d = sau_pkg::ST_SHORT;
              end else begin
                state_d = sau_pkg::S_READ;
              end
            end
            default: ;  // unused opcodes leave the stack alone
          endcase
        end
      end

      // Second word arrives from RAM; top word is in top_q
      sau_pkg::S_READ: begin
        state_d = sau_pkg::S_WB;
        case (op_q)
          sau_pkg::OP_ADD: res_d = ram_rdata + top_q;
          sau_pkg::OP_SUB: res_d = ram_rdata - top_q;
          sau_pkg::OP_MUL: res_d = W'(ram_rdata * top_q);
          default: begin
            if (top_q == '0) begin
              status_d = sau_pkg::ST_DIVZERO;
              state_d  = sau_pkg::S_DONE;
            end else begin
              dvd_d   = ram_rdata[W-1] ? (W'(0) - ram_rdata) : ram_rdata;
              dsr_d   = top_q[W-1] ? (W'(0) - top_q) : top_q;
              rem_d   = '0;
              bit_d   = '0;
              qneg_d  = ram_rdata[W-1] ^ top_q[W-1];
              rneg_d  = ram_rdata[W-1];
              state_d = sau_pkg::S_DIV;
            end
          end
        endcase
      end

      // One quotient bit per cycle, sign fix on the last step
      sau_pkg::S_DIV: begin
        dvd_d = div_quo_nx;
        rem_d = div_rem_nx;
        bit_d = bit_q + sau_pkg::BIT_W'(1);
        if (bit_q == sau_pkg::BIT_W'(W - 1)) begin
          if (op_q == sau_pkg::OP_MOD) begin
            res_d = rneg_q ? (W'(0) - div_rem_nx) : div_rem_nx;
          end else begin
            res_d = qneg_q ? (W'(0) - div_quo_nx) : div_quo_nx;
          end
          state_d = sau_pkg::S_WB;
        end
      end

      // Replace the second word with the result and pop
      sau_pkg::S_WB: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_minus2[sau_pkg::ADDR_W-1:0];
        ram_wdata = res_q;
        top_d     = res_q;
        count_d   = count_q - sau_pkg::CNT_W'(1);
        state_d   = sau_pkg::S_DONE;
      end

      // Post the result word once the output register is free
      sau_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_top_d    = (count_q == '0) ? '0 : top_q;
          out_depth_d  = sau_pkg::DEPTH_W'(count_q);
          out_status_d = status_q;
          state_d      = sau_pkg::S_IDLE;
        end
      end

      default: state_d = sau_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sau_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      bit_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      bit_q       <= bit_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    status_q     <= status_d;
    top_q        <= top_d;
    res_q        <= res_d;
    dvd_q        <= dvd_d;
    rem_q        <= rem_d;
    dsr_q        <= dsr_d;
    qneg_q       <= qneg_d;
    rneg_q       <= rneg_d;
    out_top_q    <= out_top_d;
    out_depth_q  <= out_depth_d;
    out_status_q <= out_status_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.top_value = out_top_q;
  assign out_o.depth     = out_depth_q;
  assign out_o.status    = out_status_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sau_pkg::CNT_W'(sau_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  a_wb_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sau_pkg::S_WB |=> count_q == $past(count_q) - sau_pkg::CNT_W'(1))
    else $error("write back did not pop one word");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sau_pkg::S_DIV && bit_q == sau_pkg::BIT_W'(W - 1))
      |=> state_q == sau_pkg::S_WB)
    else $error("divider did not finish after last bit");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q && !out_o.ready))
      |-> $past(state_q) == sau_pkg::S_DONE)
    else $error("result word posted outside final state");

  a_divzero_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sau_pkg::S_DONE && status_q == sau_pkg::ST_DIVZERO)
      |-> (op_q == sau_pkg::OP_DIV || op_q == sau_pkg::OP_MOD))
    else $error("zero divisor status on a non-divide opcode");

endmodule

// File: verif/stack_arithmetic_unit_tb.sv
// Testbench of the stack arithmetic unit: directed and random opcode streams.
module stack_arithmetic_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [sau_pkg::OP_W-1:0]   OP_NOP6     = 3'd6;
  localparam logic [sau_pkg::OP_W-1:0]   OP_NOP7     = 3'd7;
  localparam logic [sau_pkg::WORD_W-1:0] WORD_MIN    = 32'h8000_0000;
  localparam logic [sau_pkg::WORD_W-1:0] WORD_MAX    = 32'h7fff_ffff;
  localparam logic [sau_pkg::WORD_W-1:0] WORD_ONES   = 32'hffff_ffff;
  localparam int unsigned                CYCLE_LIMIT = 600_000;
  localparam int unsigned                TAIL_CYCLES = 60;
  localparam int unsigned                LOG_CAP     = 40;

  typedef struct packed {
    logic [sau_pkg::WORD_W-1:0]  top;
    logic [sau_pkg::DEPTH_W-1:0] depth;
    sau_pkg::status_e            status;
  } stack_view_t;

  logic clk_i;
  logic rst_ni;

  sau_in_if  in_bus ();
  sau_out_if out_bus ();

  stack_arithmetic_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Predicted stack contents and the views still owed by the unit
  logic [sau_pkg::WORD_W-1:0] stack_words [sau_pkg::STACK_DEPTH];
  int unsigned                stack_depth = 0;
  stack_view_t                pending_views [$];

  int unsigned errors      = 0;
  int unsigned cycles      = 0;
  int unsigned ready_stall = 0;
  bit          idle_on     = 1'b1;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  task automatic flag_error(input string msg);
    if (errors < LOG_CAP) $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  // Step the predicted stack by one opcode and return the view it leaves
  function automatic stack_view_t apply_opcode(input logic [sau_pkg::OP_W-1:0] op,
                                               input logic [sau_pkg::WORD_W-1:0] value);
    logic [sau_pkg::WORD_W-1:0] tos, nos, res, mag_n, mag_d, quo, rem;
    sau_pkg::status_e           st;
    stack_view_t                view;
    st  = sau_pkg::ST_OK;
    res = '0;
    if (op == sau_pkg::OP_PUSH) begin
      if (stack_depth >= sau_pkg::STACK_DEPTH) begin
        st = sau_pkg::ST_FULL;
      end else begin
        stack_words[stack_depth] = value;
        stack_depth++;
      end
    end else if (op <= sau_pkg::OP_MOD) begin
      if (stack_depth < 2) begin
        st = sau_pkg::ST_SHORT;
      end else begin
        tos = stack_words[stack_depth-1];
        nos = stack_words[stack_depth-2];
        case (op)
          sau_pkg::OP_ADD: res = nos + tos;
          sau_pkg::OP_SUB: res = nos - tos;
          sau_pkg::OP_MUL: res = nos * tos;
          default: begin
            if (tos == '0) begin
              st = sau_pkg::ST_DIVZERO;
            end else begin
              // divide magnitudes, then fix signs: quotient toward zero,
              // remainder follows the dividend
              mag_n = nos[sau_pkg::WORD_W-1] ? -nos : nos;
              mag_d = tos[sau_pkg::WORD_W-1] ? -tos : tos;
              quo   = mag_n / mag_d;
              rem   = mag_n % mag_d;
              if (op == sau_pkg::OP_MOD) res = nos[sau_pkg::WORD_W-1] ? -rem : rem;
              else res = (nos[sau_pkg::WORD_W-1] ^ tos[sau_pkg::WORD_W-1]) ? -quo : quo;
            end
          end
        endcase
        if (st == sau_pkg::ST_OK) begin
          stack_depth--;
          stack_words[stack_depth-1] = res;
        end
      end
    end
    view.top    = (stack_depth == 0) ? '0 : stack_words[stack_depth-1];
    view.depth  = sau_pkg::DEPTH_W'(stack_depth);
    view.status = st;
    return view;
  endfunction

  // Drive one word after a random gap when idle_on is set and predict its result on acceptance
  task automatic send_word(input logic [sau_pkg::OP_W-1:0] op,
                           input logic [sau_pkg::WORD_W-1:0] value);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_bus.valid      <= 1'b1;
    in_bus.opcode     <= op;
    in_bus.push_value <= value;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    pending_views.push_back(apply_opcode(op, value));
  endtask

  // Hold off the sender until every predicted result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
  endtask

  // Operand mix weighted toward the edges of the signed range
  function automatic logic [sau_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return WORD_ONES;
      4, 5: return sau_pkg::WORD_W'($urandom_range(0, 32)) - 32'd16;
      6: return 32'd1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [sau_pkg::OP_W-1:0] pick_arith();
    return sau_pkg::OP_ADD + sau_pkg::OP_W'($urandom_range(0, 4));
  endfunction

  task automatic test_empty_stack();
    send_word(sau_pkg::OP_ADD, $urandom());
    send_word(sau_pkg::OP_SUB, $urandom());
    send_word(sau_pkg::OP_MUL, $urandom());
    send_word(sau_pkg::OP_DIV, $urandom());
    send_word(sau_pkg::OP_MOD, $urandom());
    send_word(OP_NOP6, $urandom());
    send_word(OP_NOP7, $urandom());
    send_word(sau_pkg::OP_PUSH, 32'd5);
    // one word is still too short
    send_word(sau_pkg::OP_MOD, $urandom());
  endtask

  task automatic test_arith_ops();
    send_word(sau_pkg::OP_PUSH, WORD_MAX);
    send_word(sau_pkg::OP_PUSH, 32'd1);
    send_word(sau_pkg::OP_ADD, '0);
    send_word(sau_pkg::OP_PUSH, WORD_ONES);
    send_word(sau_pkg::OP_SUB, '0);
    send_word(sau_pkg::OP_PUSH, WORD_MIN);
    send_word(sau_pkg::OP_MUL, '0);
  endtask

  task automatic test_divide_corners();
    // zero divisor leaves the stack alone
    send_word(sau_pkg::OP_PUSH, '0);
    send_word(sau_pkg::OP_DIV, '0);
    send_word(sau_pkg::OP_MOD, '0);
    // most negative over minus one wraps, remainder zero
    send_word(sau_pkg::OP_PUSH, WORD_MIN);
    send_word(sau_pkg::OP_PUSH, WORD_ONES);
    send_word(sau_pkg::OP_DIV, '0);
    send_word(sau_pkg::OP_PUSH, WORD_MIN);
    send_word(sau_pkg::OP_PUSH, WORD_ONES);
    send_word(sau_pkg::OP_MOD, '0);
    // negative dividend: truncation and remainder sign
    send_word(sau_pkg::OP_PUSH, -32'sd7);
    send_word(sau_pkg::OP_PUSH, 32'd2);
    send_word(sau_pkg::OP_MOD, '0);
    wait_drained();
  endtask

  task automatic test_full_stack();
    idle_on = 1'b0;
    while (stack_depth < sau_pkg::STACK_DEPTH) send_word(sau_pkg::OP_PUSH, pick_word());
    send_word(sau_pkg::OP_PUSH, pick_word());
    send_word(OP_NOP7, $urandom());
    send_word(sau_pkg::OP_PUSH, pick_word());
    idle_on = 1'b1;
    while (stack_depth > 1) send_word(pick_arith(), $urandom());
    wait_drained();
  endtask

  task automatic test_random_walk(input int unsigned n_items);
    int unsigned                push_pct;
    int unsigned                r;
    logic [sau_pkg::OP_W-1:0]   op;
    push_pct = 50;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 3))
          0: push_pct = 20;
          1: push_pct = 80;
          default: push_pct = 50;
        endcase
        idle_on = ($urandom_range(0, 4) != 0);
      end
      if (i % 300 == 299) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 4) begin
        op = r[0] ? OP_NOP7 : OP_NOP6;
      end else if ($urandom_range(0, 99) < ((stack_depth < 2) ? 75 : push_pct)) begin
        op = sau_pkg::OP_PUSH;
      end else begin
        op = pick_arith();
      end
      send_word(op, (op == sau_pkg::OP_PUSH) ? pick_word() : $urandom());
    end
    wait_drained();
  endtask

  // Result ready: held low for a random stall after each accepted result while idle_on is set
  always @(negedge clk_i) begin
    if (ready_stall > 0) begin
      out_bus.ready <= 1'b0;
      ready_stall--;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest prediction; watchdog
  always @(posedge clk_i) begin
    stack_view_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("stack_arithmetic_unit_tb: FAIL");
      $finish;
    end else if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_views.size() == 0) begin
        flag_error($sformatf("unexpected result top=%h depth=%0d status=%0d",
                             out_bus.top_value, out_bus.depth, out_bus.status));
      end else begin
        want = pending_views.pop_front();
        if (out_bus.top_value !== want.top)
          flag_error($sformatf("top_value got %h want %h", out_bus.top_value, want.top));
        if (out_bus.depth !== want.depth)
          flag_error($sformatf("depth got %0d want %0d", out_bus.depth, want.depth));
        if (out_bus.status !== want.status)
          flag_error($sformatf("status got %0d want %0d", out_bus.status, want.status));
      end
      ready_stall = idle_on ? $urandom_range(0, 9) : 0;
    end
  end

  initial begin
    rst_ni            = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.opcode     = sau_pkg::OP_PUSH;
    in_bus.push_value = '0;
    out_bus.ready     = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_stack();
    test_arith_ops();
    test_divide_corners();
    test_full_stack();
    test_random_walk(700);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_views.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_views.size()));
    if (errors == 0) begin
      $display("stack_arithmetic_unit_tb: PASS");
    end else begin
      $display("stack_arithmetic_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
